// ===== rtl/ipl_pkg.sv =====
`default_nettype none
package ipl_pkg;

    localparam int CAPACITY = 255;
    localparam int HALF_W   = 64;
    localparam int ID_W     = 2 * HALF_W;
    localparam int IDX_W    = $clog2(CAPACITY + 1);
    localparam int RAM_AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // datapath operations, one per microprogram step
    typedef enum logic [2:0] {
        OP_ACCEPT   = 3'd0,
        OP_CHK_LAST = 3'd1,
        OP_SEARCH   = 3'd2,
        OP_INS_NULL = 3'd3,
        OP_APPEND   = 3'd4
    } t_op;

    typedef logic [2:0] t_step;

    localparam t_step ST_WAIT     = 3'd0;
    localparam t_step ST_CHK_LAST = 3'd1;
    localparam t_step ST_SEARCH   = 3'd2;
    localparam t_step ST_INS_NULL = 3'd3;
    localparam t_step ST_APPEND   = 3'd4;

    typedef struct packed {
        logic  busy;
        t_op   op;
        t_step j_jump;
        t_step j_next;
    } t_ucode;

    typedef struct packed {
        logic done;
        logic jump;
    } t_stat;

    function automatic t_ucode ucode_rom(input t_step addr);
        t_ucode w;
        w = '{busy: 1'b1, op: OP_ACCEPT, j_jump: ST_WAIT, j_next: ST_WAIT};
        unique case (addr)
            ST_WAIT:     w = '{busy: 1'b0, op: OP_ACCEPT,
                               j_jump: ST_CHK_LAST, j_next: ST_WAIT};
            ST_CHK_LAST: w = '{busy: 1'b1, op: OP_CHK_LAST,
                               j_jump: ST_INS_NULL, j_next: ST_SEARCH};
            ST_SEARCH:   w = '{busy: 1'b1, op: OP_SEARCH,
                               j_jump: ST_APPEND, j_next: ST_SEARCH};
            ST_INS_NULL: w = '{busy: 1'b1, op: OP_INS_NULL,
                               j_jump: ST_APPEND, j_next: ST_APPEND};
            ST_APPEND:   w = '{busy: 1'b1, op: OP_APPEND,
                               j_jump: ST_WAIT, j_next: ST_WAIT};
            default:     w = '{busy: 1'b1, op: OP_ACCEPT,
                               j_jump: ST_WAIT, j_next: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ipl_ram.sv =====
`default_nettype none
module ipl_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/ipl_sequencer.sv =====
`default_nettype none
module ipl_sequencer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ipl_pkg::t_stat i_stat,
    output ipl_pkg::t_ucode     o_ucode
);
    import ipl_pkg::*;

    t_step r_step;
    t_step n_step;

    assign o_ucode = ucode_rom(r_step);

    always_comb begin
        if (i_stat.done) begin
            n_step = ST_WAIT;
        end else if (i_stat.jump) begin
            n_step = o_ucode.j_jump;
        end else begin
            n_step = o_ucode.j_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ipl_datapath.sv =====
`default_nettype none
module ipl_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ipl_pkg::t_ucode              i_ucode,
    input  wire logic                         i_start,
    input  wire logic [ipl_pkg::HALF_W-1:0]   i_id_high,
    input  wire logic [ipl_pkg::HALF_W-1:0]   i_id_low,
    output ipl_pkg::t_stat                    o_stat,
    output logic                              o_done,
    output logic      [ipl_pkg::IDX_W-1:0]    o_index,
    output logic                              o_full_miss,
    output logic      [ipl_pkg::IDX_W-1:0]    o_entries_used
);
    import ipl_pkg::*;

    logic [ID_W-1:0]  r_id,    n_id;
    logic [IDX_W-1:0] r_ptr,   n_ptr;
    logic [IDX_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_last,  n_last;
    logic             r_done,  n_done;
    logic [IDX_W-1:0] r_index, n_index;
    logic             r_miss,  n_miss;
    logic [IDX_W-1:0] r_used,  n_used;

    logic              wr_en;
    logic [RAM_AW-1:0] wr_addr;
    logic [ID_W-1:0]   wr_data;
    logic [ID_W-1:0]   rd_data;
    logic              match;
    logic              is_null;
    logic [IDX_W-1:0]  ptr_inc;

    // read address follows the next pointer, so rd_data always holds entry r_ptr
    ipl_ram #(
        .WIDTH (ID_W),
        .DEPTH (CAPACITY),
        .ADDR_W(RAM_AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(n_ptr[RAM_AW-1:0]),
        .o_rd_data(rd_data)
    );

    assign match   = (rd_data == r_id);
    assign is_null = (r_id == '0);
    assign ptr_inc = r_ptr + 1'b1;

    always_comb begin
        n_id    = r_id;
        n_ptr   = r_ptr;
        n_count = r_count;
        n_last  = r_last;
        n_done  = 1'b0;
        n_index = r_index;
        n_miss  = r_miss;
        n_used  = r_used;
        wr_en   = 1'b0;
        wr_addr = r_count[RAM_AW-1:0];
        wr_data = r_id;
        o_stat  = '{done: 1'b0, jump: 1'b0};

        unique case (i_ucode.op)
            OP_ACCEPT: begin
                if (i_start) begin
                    n_id        = {i_id_high, i_id_low};
                    n_ptr       = r_last;
                    o_stat.jump = 1'b1;
                end
            end
            OP_CHK_LAST: begin
                if ((r_last < r_count) && match) begin
                    o_stat.done = 1'b1;
                    n_done      = 1'b1;
                    n_index     = r_last;
                    n_miss      = 1'b0;
                    n_used      = r_count;
                end else if (is_null && (r_count != '0)) begin
                    o_stat.done = 1'b1;
                    n_done      = 1'b1;
                    n_index     = '0;
                    n_miss      = 1'b0;
                    n_used      = r_count;
                end else if (r_count == '0) begin
                    o_stat.jump = 1'b1;
                end else begin
                    n_ptr = '0;
                end
            end
            OP_SEARCH: begin
                if (match) begin
                    o_stat.done = 1'b1;
                    n_done      = 1'b1;
                    n_index     = r_ptr;
                    n_miss      = 1'b0;
                    n_used      = r_count;
                    if (r_ptr != '0) begin
                        n_last = r_ptr;
                    end
                end else if (ptr_inc == r_count) begin
                    o_stat.jump = 1'b1;
                end else begin
                    n_ptr = ptr_inc;
                end
            end
            OP_INS_NULL: begin
                // entry 0 holds the null identifier
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '0;
                n_count = IDX_W'(1);
                if (is_null) begin
                    o_stat.done = 1'b1;
                    n_done      = 1'b1;
                    n_index     = '0;
                    n_miss      = 1'b0;
                    n_used      = IDX_W'(1);
                end
            end
            OP_APPEND: begin
                o_stat.done = 1'b1;
                n_done      = 1'b1;
                if (r_count >= IDX_W'(CAPACITY)) begin
                    n_index = '0;
                    n_miss  = 1'b1;
                    n_used  = r_count;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                    n_last  = r_count;
                    n_index = r_count;
                    n_miss  = 1'b0;
                    n_used  = r_count + 1'b1;
                end
            end
            default: begin
                o_stat.done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_count <= '0;
            r_last  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_ptr   <= n_ptr;
            r_count <= n_count;
            r_last  <= n_last;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_index <= n_index;
        r_miss  <= n_miss;
        r_used  <= n_used;
    end

    assign o_done         = r_done;
    assign o_index        = r_index;
    assign o_full_miss    = r_miss;
    assign o_entries_used = r_used;

endmodule
`default_nettype wire

// ===== rtl/id_palette_lookup_or_insert_unit.sv =====
`default_nettype none
// Channel   Ports                                   Transfer
// command   start, i_id_high, i_id_low              start && !busy at rising edge
// result    o_done, o_index, o_full_miss,           o_done high for one cycle
//           o_entries_used
//
// A microprogram of five steps runs one identifier at a time. Last-hit answers and
// null on a non-empty palette are decided in the check-last step, the first insert in the
// insert-null step (null) or append step; a search reads one palette entry per cycle from a
// single RAM port from index 0 up, a miss ending in append. The result strobes in the cycle after
// the deciding step, and the next start is taken in that same cycle. Reset empties the
// palette at once (entry count and last hit cleared, no RAM sweep). The result side cannot stall.
module id_palette_lookup_or_insert_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [ipl_pkg::HALF_W-1:0] i_id_high,
    input  wire logic [ipl_pkg::HALF_W-1:0] i_id_low,
    output logic                            o_done,
    output logic      [ipl_pkg::IDX_W-1:0]  o_index,
    output logic                            o_full_miss,
    output logic      [ipl_pkg::IDX_W-1:0]  o_entries_used
);
    import ipl_pkg::*;

    t_ucode ucode;
    t_stat  stat;

    ipl_sequencer u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (stat),
        .o_ucode(ucode)
    );

    ipl_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ucode       (ucode),
        .i_start       (start),
        .i_id_high     (i_id_high),
        .i_id_low      (i_id_low),
        .o_stat        (stat),
        .o_done        (o_done),
        .o_index       (o_index),
        .o_full_miss   (o_full_miss),
        .o_entries_used(o_entries_used)
    );

    assign busy = ucode.busy;

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_full_miss) |-> (o_index == '0))
        else $error("full miss with nonzero index");

    a_miss_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_full_miss) |-> (o_entries_used == IDX_W'(CAPACITY)))
        else $error("full miss while palette has room");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_full_miss) |-> (o_index < o_entries_used))
        else $error("index beyond entries in use");

endmodule
`default_nettype wire
